>>> rtl/core/etd_pkg.sv
// shared types, character codes and sizes for the escape text decoder
package etd_pkg;

  localparam int unsigned CAP_W      = 15;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 15'd255;

  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_ESCAPE = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LO_R  = 8'h72;
  localparam logic [BYTE_W-1:0] CH_UP_R  = 8'h52;
  localparam logic [BYTE_W-1:0] CH_LO_N  = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_UP_N  = 8'h4E;
  localparam logic [BYTE_W-1:0] CH_LO_T  = 8'h74;
  localparam logic [BYTE_W-1:0] CH_UP_T  = 8'h54;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_SEVEN = 8'h37;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;

  typedef struct packed {
    logic              truncated;
    logic              string_end;
    logic              run_last;
    logic              byte_valid;
    logic [BYTE_W-1:0] data;
  } res_t;

endpackage

>>> rtl/core/escape_text_decoder.sv
// top level of the escape text decoder: stream ports, config port, decode and queue
// a result beat is registered into the queue and offered once it reaches the head
// one input beat per cycle while in_tready, one result beat per cycle while out_tready
// an input beat that yields two result beats pushes both into the queue together
// in_tready is high while the result queue has room for two beats
// reset: synchronous active low, clears decode state and queue, capacity returns to 255
module escape_text_decoder #(
  parameter int unsigned FifoDepth = etd_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [2:0]  out_tuser,  // [0] byte_valid, [1] string_end, [2] truncated
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [etd_pkg::CAP_W-1:0] capacity;
  logic                      accept;
  logic                      room2;
  logic [1:0]                res_n;
  logic [1:0]                push_n;
  etd_pkg::res_t             res0, res1, head;

  assign in_tready = room2;
  assign accept    = in_tvalid && in_tready;
  assign push_n    = accept ? res_n : 2'd0;

  etd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .capacity (capacity)
  );

  etd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .capacity (capacity),
    .res0     (res0),
    .res1     (res1),
    .res_n    (res_n)
  );

  etd_out_fifo #(
    .Depth (FifoDepth)
  ) u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .din0       (res0),
    .din1       (res1),
    .room2      (room2),
    .dout_valid (out_tvalid),
    .dout_ready (out_tready),
    .dout       (head)
  );

  assign out_tdata = head.data;
  assign out_tuser = {head.truncated, head.string_end, head.byte_valid};
  assign out_tlast = head.run_last;

endmodule

>>> rtl/core/etd_cfg.sv
// configuration register file: capacity register behind an apb-style port
module etd_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [1:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [etd_pkg::CAP_W-1:0] capacity
);

  localparam logic [1:0] ADDR_CAPACITY = 2'd0;

  logic [etd_pkg::CAP_W-1:0] cap_r;
  logic [etd_pkg::CAP_W-1:0] cap_nxt;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cap_nxt = cap_r;
    if (wr_en) begin
      cap_nxt = pwdata[etd_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= etd_pkg::CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  assign prdata   = (paddr == ADDR_CAPACITY) ?
                    {{(32-etd_pkg::CAP_W){1'b0}}, cap_r} : 32'd0;
  assign capacity = cap_r;

endmodule

>>> rtl/core/etd_decode.sv
// escape decode state and per-beat result generation with capacity gating
module etd_decode (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [etd_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_last,
  input  logic [etd_pkg::CAP_W-1:0]  capacity,
  output etd_pkg::res_t              res0,
  output etd_pkg::res_t              res1,
  output logic [1:0]                 res_n
);

  logic [1:0]                 phase_r, phase_nxt;
  logic [1:0]                 dcnt_r, dcnt_nxt;
  logic [etd_pkg::BYTE_W-1:0] oval_r, oval_nxt;
  logic [etd_pkg::CAP_W-1:0]  emitted_r, emitted_nxt;

  logic [etd_pkg::BYTE_W-1:0] cand [2];
  logic [1:0]                 ncand;
  logic [1:0]                 nok;
  logic                       is_oct;
  logic                       do_plain;
  logic                       ok0, ok1;
  logic [etd_pkg::CAP_W:0]    e_ext, c_ext, e_p1, e_p2;

  assign is_oct = (in_byte >= etd_pkg::CH_ZERO) && (in_byte <= etd_pkg::CH_SEVEN);
  assign e_ext  = {1'b0, emitted_r};
  assign c_ext  = {1'b0, capacity};
  assign e_p1   = e_ext + {{etd_pkg::CAP_W{1'b0}}, 1'b1};
  assign e_p2   = e_ext + {{(etd_pkg::CAP_W-1){1'b0}}, 2'd2};

  always_comb begin
    cand[0]   = '0;
    cand[1]   = '0;
    ncand     = 2'd0;
    phase_nxt = phase_r;
    dcnt_nxt  = dcnt_r;
    oval_nxt  = oval_r;
    do_plain  = 1'b0;

    case (phase_r)
      etd_pkg::PH_ESCAPE: begin
        if (in_byte == etd_pkg::CH_LO_R || in_byte == etd_pkg::CH_UP_R) begin
          phase_nxt = etd_pkg::PH_NORMAL;
          cand[0]   = etd_pkg::CH_CR;
          ncand     = 2'd1;
        end else if (in_byte == etd_pkg::CH_LO_N || in_byte == etd_pkg::CH_UP_N) begin
          phase_nxt = etd_pkg::PH_NORMAL;
          cand[0]   = etd_pkg::CH_LF;
          ncand     = 2'd1;
        end else if (in_byte == etd_pkg::CH_LO_T || in_byte == etd_pkg::CH_UP_T) begin
          phase_nxt = etd_pkg::PH_NORMAL;
          cand[0]   = etd_pkg::CH_TAB;
          ncand     = 2'd1;
        end else if (is_oct) begin
          phase_nxt = etd_pkg::PH_DIGITS;
          dcnt_nxt  = 2'd1;
          oval_nxt  = {5'd0, in_byte[2:0]};
        end else begin
          cand[0]  = '0;
          ncand    = 2'd1;
          do_plain = 1'b1;
        end
      end
      etd_pkg::PH_DIGITS: begin
        if (is_oct) begin
          oval_nxt = {oval_r[4:0], in_byte[2:0]};
          dcnt_nxt = dcnt_r + 2'd1;
          if (dcnt_nxt == etd_pkg::OCT_MAX_DIGITS || dcnt_nxt == 2'd0) begin
            phase_nxt = etd_pkg::PH_NORMAL;
            cand[0]   = oval_nxt;
            ncand     = 2'd1;
          end
        end else begin
          cand[0]  = oval_r;
          ncand    = 2'd1;
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (in_byte == etd_pkg::CH_BSL) begin
        phase_nxt = etd_pkg::PH_ESCAPE;
        dcnt_nxt  = 2'd0;
        oval_nxt  = '0;
      end else begin
        phase_nxt       = etd_pkg::PH_NORMAL;
        cand[ncand[0]]  = in_byte;
        ncand           = ncand + 2'd1;
      end
    end

    // end of string flushes a pending escape
    if (in_last) begin
      if (phase_nxt == etd_pkg::PH_ESCAPE) begin
        cand[ncand[0]] = '0;
        ncand          = ncand + 2'd1;
      end else if (phase_nxt == etd_pkg::PH_DIGITS) begin
        cand[ncand[0]] = oval_nxt;
        ncand          = ncand + 2'd1;
      end
    end

    ok0 = (ncand != 2'd0) && (e_ext < c_ext);
    ok1 = (ncand == 2'd2) && (e_p1 < c_ext);
    nok = ok0 ? (ok1 ? 2'd2 : 2'd1) : 2'd0;

    res0.data       = cand[0];
    res0.byte_valid = 1'b1;
    res0.truncated  = (e_p1 >= c_ext);
    res0.run_last   = (nok == 2'd1);
    res0.string_end = in_last && (nok == 2'd1);

    res1.data       = cand[1];
    res1.byte_valid = 1'b1;
    res1.truncated  = (e_p2 >= c_ext);
    res1.run_last   = 1'b1;
    res1.string_end = in_last;

    res_n = nok;
    if (in_last && nok == 2'd0) begin
      res0.data       = '0;
      res0.byte_valid = 1'b0;
      res0.truncated  = (e_ext >= c_ext);
      res0.run_last   = 1'b1;
      res0.string_end = 1'b1;
      res_n           = 2'd1;
    end

    if (in_last) begin
      phase_nxt   = etd_pkg::PH_NORMAL;
      dcnt_nxt    = 2'd0;
      oval_nxt    = '0;
      emitted_nxt = '0;
    end else begin
      emitted_nxt = emitted_r + {{(etd_pkg::CAP_W-2){1'b0}}, nok};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= etd_pkg::PH_NORMAL;
      dcnt_r    <= 2'd0;
      oval_r    <= '0;
      emitted_r <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      dcnt_r    <= dcnt_nxt;
      oval_r    <= oval_nxt;
      emitted_r <= emitted_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> phase_r == etd_pkg::PH_NORMAL && emitted_r == '0 && dcnt_r == 2'd0)
    else $error("string end did not clear decode state");

  a_digits_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == etd_pkg::PH_DIGITS |-> dcnt_r == 2'd1 || dcnt_r == 2'd2)
    else $error("digit count out of range while gathering digits");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_last && ({1'b0, emitted_r} >= {1'b0, capacity})
    |=> emitted_r == $past(emitted_r))
    else $error("emitted count grew past capacity");

endmodule

>>> rtl/core/etd_out_fifo.sv
// result queue: takes up to two result beats per cycle, drains one per cycle while dout_ready is high
module etd_out_fifo #(
  parameter int unsigned Depth = etd_pkg::FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  etd_pkg::res_t din0,
  input  etd_pkg::res_t din1,
  output logic          room2,
  output logic          dout_valid,
  input  logic          dout_ready,
  output etd_pkg::res_t dout
);

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(Depth - 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(Depth - 2);
  localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

  etd_pkg::res_t mem_r [Depth];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr1;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + PW'(1);
  endfunction

  assign pop        = dout_valid && dout_ready;
  assign dout_valid = (count_r != '0);
  assign dout       = mem_r[rd_ptr_r];
  assign room2      = (count_r <= ROOM_MAX);
  assign wr_ptr1    = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push_n == 2'd1) begin
      wr_ptr_nxt = wr_ptr1;
    end else if (push_n == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr1);
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= din0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr1] <= din1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |-> room2)
    else $error("push without room for two beats");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    push_n == 2'd0 && pop |=> count_r == $past(count_r) - CW'(1))
    else $error("queue count wrong after pop");

endmodule
